// ===== sv/baa_pkg.sv =====
`timescale 1ns / 1ps
// baa_pkg: shared types, codes and constants for the bump arena allocator
// no dependencies

package baa_pkg;

    // arena geometry
    localparam int OFFSET_BITS = 24;
    localparam int MAX_REGIONS = 255;

    localparam int OFS_W   = 25;
    localparam int ADDR_W  = 32;
    localparam int ALIGN_W = 16;
    localparam int DEPTH_W = 8;

    // effective capacity is capped only when the offset space is narrower than the field
    localparam bit CAP_LIMITED = (OFFSET_BITS < OFS_W);
    localparam logic [OFS_W-1:0] CAP_LIMIT =
        CAP_LIMITED ? OFS_W'(64'd1 << OFFSET_BITS) : {OFS_W{1'b1}};

    // region nesting limit is min(MAX_REGIONS, 255)
    localparam logic [DEPTH_W-1:0] REGION_LIMIT =
        (MAX_REGIONS < 255) ? DEPTH_W'(MAX_REGIONS) : DEPTH_W'(255);

    typedef enum logic [2:0] {
        MODE_ALLOCATE     = 3'd0,
        MODE_RESIZE       = 3'd1,
        MODE_RESET        = 3'd2,
        MODE_REGION_BEGIN = 3'd3,
        MODE_REGION_END   = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_BAD_ALIGN    = 3'd2,
        ST_NOT_OWNED    = 3'd3,
        ST_NOT_LAST     = 3'd4,
        ST_REGIONS_OPEN = 3'd5,
        ST_REGION_LIMIT = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        REG_BASE_ADDRESS = 1'd0,
        REG_CAPACITY     = 1'd1
    } reg_index_t;

    typedef struct packed {
        logic [OFS_W-1:0]   used_offset;
        logic [OFS_W-1:0]   last_block_offset;
        logic               last_block_valid;
        logic [DEPTH_W-1:0] open_regions;
    } arena_state_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [ADDR_W-1:0]  block_address;
        logic [OFS_W-1:0]   current_offset;
        logic [DEPTH_W-1:0] region_depth;
    } result_t;

endpackage

// ===== sv/baa_op_unit.sv =====
`timescale 1ns / 1ps
// baa_op_unit: single-pass operation logic, arena state and request in, next state and result out
// depends on baa_pkg

module baa_op_unit import baa_pkg::*;
(
    input  logic [2:0]         mode,
    input  logic [OFS_W-1:0]   size,
    input  logic [ALIGN_W-1:0] align,
    input  logic [ADDR_W-1:0]  address,
    input  logic [OFS_W-1:0]   saved_offset,
    input  logic [ADDR_W-1:0]  base_address,
    input  logic [OFS_W-1:0]   capacity,
    input  arena_state_t       state_cur,
    output arena_state_t       state_next,
    output result_t            result
);

    logic [OFS_W-1:0]   eff_cap;
    logic [ALIGN_W-1:0] align_mask;
    logic               align_ok;
    logic [ALIGN_W-1:0] cur_lo;
    logic [ALIGN_W-1:0] pad;
    logic [OFS_W:0]     required;
    logic [OFS_W-1:0]   avail;
    logic               alloc_fits;
    logic [OFS_W-1:0]   alloc_ofs;
    logic [OFS_W-1:0]   alloc_end;
    logic [ADDR_W-1:0]  alloc_addr;
    logic [ADDR_W:0]    window_end;
    logic               outside;
    logic [ADDR_W-1:0]  rel_addr;
    logic               is_last;
    logic [OFS_W:0]     resize_end;
    logic               resize_fits;
    logic [OFS_W-1:0]   restored;
    status_t            status;

    assign eff_cap = (CAP_LIMITED && (capacity > CAP_LIMIT)) ? CAP_LIMIT : capacity;

    // allocate: padding only depends on the low address bits
    assign align_mask = align - ALIGN_W'(1);
    assign align_ok   = (align != '0) && ((align & align_mask) == '0);
    assign cur_lo     = base_address[ALIGN_W-1:0] + state_cur.used_offset[ALIGN_W-1:0];
    assign pad        = (~cur_lo + ALIGN_W'(1)) & align_mask;
    assign required   = {{(OFS_W+1-ALIGN_W){1'b0}}, pad} + {1'b0, size};
    assign avail      = (eff_cap > state_cur.used_offset) ? (eff_cap - state_cur.used_offset) : '0;
    assign alloc_fits = (required <= {1'b0, avail});
    assign alloc_ofs  = state_cur.used_offset + {{(OFS_W-ALIGN_W){1'b0}}, pad};
    assign alloc_end  = alloc_ofs + size;
    assign alloc_addr = base_address + {{(ADDR_W-OFS_W){1'b0}}, alloc_ofs};

    // resize: window check, ownership of the last block, room for the new end
    assign window_end  = {1'b0, base_address} + {{(ADDR_W+1-OFS_W){1'b0}}, eff_cap};
    assign outside     = (address < base_address) || ({1'b0, address} >= window_end);
    assign rel_addr    = address - base_address;
    assign is_last     = state_cur.last_block_valid
                         && (rel_addr == {{(ADDR_W-OFS_W){1'b0}}, state_cur.last_block_offset});
    assign resize_end  = {1'b0, state_cur.last_block_offset} + {1'b0, size};
    assign resize_fits = (resize_end <= {1'b0, eff_cap});

    // region end: clamp the restored offset
    assign restored = (saved_offset < eff_cap) ? saved_offset : eff_cap;

    always_comb
    begin
        state_next           = state_cur;
        status               = ST_OK;
        result.block_address = '0;
        case (mode)
            MODE_ALLOCATE:
            begin
                if (!align_ok)
                begin
                    status = ST_BAD_ALIGN;
                end
                else if (!alloc_fits)
                begin
                    status = ST_NO_SPACE;
                end
                else
                begin
                    state_next.last_block_offset = alloc_ofs;
                    state_next.last_block_valid  = 1'b1;
                    state_next.used_offset       = alloc_end;
                    result.block_address         = alloc_addr;
                end
            end
            MODE_RESIZE:
            begin
                if (outside)
                begin
                    status = ST_NOT_OWNED;
                end
                else if (!is_last)
                begin
                    status = ST_NOT_LAST;
                end
                else if (!resize_fits)
                begin
                    status = ST_NO_SPACE;
                end
                else
                begin
                    state_next.used_offset = resize_end[OFS_W-1:0];
                    result.block_address   = address;
                end
            end
            MODE_RESET:
            begin
                if (state_cur.open_regions != '0)
                begin
                    status = ST_REGIONS_OPEN;
                end
                else
                begin
                    state_next.used_offset      = '0;
                    state_next.last_block_valid = 1'b0;
                end
            end
            MODE_REGION_BEGIN:
            begin
                if (state_cur.open_regions >= REGION_LIMIT)
                begin
                    status = ST_REGION_LIMIT;
                end
                else
                begin
                    state_next.open_regions = state_cur.open_regions + DEPTH_W'(1);
                end
            end
            MODE_REGION_END:
            begin
                if (state_cur.open_regions == '0)
                begin
                    status = ST_REGION_LIMIT;
                end
                else
                begin
                    state_next.used_offset  = restored;
                    state_next.open_regions = state_cur.open_regions - DEPTH_W'(1);
                    if (state_cur.last_block_valid && (restored <= state_cur.last_block_offset))
                    begin
                        state_next.last_block_valid = 1'b0;
                    end
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        result.status         = status;
        result.current_offset = state_next.used_offset;
        result.region_depth   = state_next.open_regions;
    end

endmodule

// ===== sv/bump_arena_allocator_top.sv =====
`timescale 1ns / 1ps
// bump_arena_allocator_top: bump allocator with region nesting, input stage and result register
// depends on baa_pkg and baa_op_unit
//
//  channel   handshake              beat contents
//  -------   ---------------------  ------------------------------------------------
//  cfg       cfg_write              cfg_index, cfg_data (base_address, capacity)
//  in        in_valid / in_ready    mode, size, align, address, saved_offset
//  out       out_valid / out_ready  status, block_address, current_offset, region_depth
//
// one beat per cycle sustained while out_ready stays high; a request is registered in the input stage,
// then its result is loaded into the result register
// the arena state is updated on the same edge that loads the result, so the following
// request always sees it
// rst_n clears configuration, arena state and both valid flags; no clearing pass
// a stalled result holds the input stage, which still takes one beat while it is empty

module bump_arena_allocator_top import baa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [ADDR_W-1:0]  cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         mode,
    input  logic [OFS_W-1:0]   size,
    input  logic [ALIGN_W-1:0] align,
    input  logic [ADDR_W-1:0]  address,
    input  logic [OFS_W-1:0]   saved_offset,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [ADDR_W-1:0]  block_address,
    output logic [OFS_W-1:0]   current_offset,
    output logic [DEPTH_W-1:0] region_depth
);

    // configuration registers
    logic [ADDR_W-1:0]  base_address_reg;
    logic [OFS_W-1:0]   capacity_reg;

    // input stage
    logic               stage_valid_reg;
    logic [2:0]         mode_reg;
    logic [OFS_W-1:0]   size_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [OFS_W-1:0]   saved_offset_reg;

    // arena state and result register
    arena_state_t       state_reg;
    arena_state_t       state_next;
    result_t            result_reg;
    result_t            result_next;
    logic               out_valid_reg;

    logic               advance;
    logic               in_take;

    // the request moves on when the result register is free or being emptied
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= '0;
            capacity_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_BASE_ADDRESS: base_address_reg <= cfg_data;
                REG_CAPACITY:     capacity_reg     <= cfg_data[OFS_W-1:0];
                default:          base_address_reg <= base_address_reg;
            endcase
        end
    end

    // input stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // input stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg         <= mode;
            size_reg         <= size;
            align_reg        <= align;
            address_reg      <= address;
            saved_offset_reg <= saved_offset;
        end
    end

    baa_op_unit u_op_unit
    (
        .mode         (mode_reg),
        .size         (size_reg),
        .align        (align_reg),
        .address      (address_reg),
        .saved_offset (saved_offset_reg),
        .base_address (base_address_reg),
        .capacity     (capacity_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (result_next)
    );

    // arena state commits together with the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign block_address  = result_reg.block_address;
    assign current_offset = result_reg.current_offset;
    assign region_depth   = result_reg.region_depth;

    // used offset never leaves the offset space
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.used_offset <= CAP_LIMIT)
        else $error("used offset beyond offset space");

    // nesting count stays within its limit
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.open_regions <= REGION_LIMIT)
        else $error("open region count beyond limit");

    // failed operations report no block address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.status != ST_OK)) |-> (result_reg.block_address == '0))
        else $error("block address on failed operation");

    // a new beat into a full input stage only when the held request moves on
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && stage_valid_reg) |-> advance)
        else $error("input stage overwritten");

    // a request that moves on always leaves a result behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost");

endmodule
